[hw/rtl/setcmd_pkg.sv]
// Package for the SET command line parser: phase codes, character constants,
// keyword text and the flag group that each keyword tracker hands to the top level.
// No dependencies.
`default_nettype none

package setcmd_pkg;

    // Width of the number accumulator; the result port is always 32 bits.
    localparam int MANT_BITS = 32;

    localparam int KW_LEN = 6;

    // Tracker phases.
    localparam logic [2:0] PH_SEARCH = 3'd0;  // keyword not found yet
    localparam logic [2:0] PH_LEAD   = 3'd1;  // spaces after the keyword
    localparam logic [2:0] PH_NUM    = 3'd2;  // inside the number
    localparam logic [2:0] PH_TRAIL  = 3'd3;  // trailing spaces
    localparam logic [2:0] PH_REJECT = 3'd4;  // line rejected

    // Keyword selection.
    localparam logic KW_TIMER = 1'b0;
    localparam logic KW_PWM   = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TIMER = 2'd1;
    localparam logic [1:0] KIND_PWM   = 2'd2;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] KW_LAST_IDX = 3'(KW_LEN - 1);

    // Flags raised by one tracker for one character.
    typedef struct packed {
        logic found;       // last keyword character matched
        logic digit_take;  // the character is a digit of the number
        logic point_set;   // the character is the (first) decimal point
    } trk_flags_t;

    // Expected keyword character at a given match position.
    function automatic logic [7:0] kw_char(input logic sel, input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_S;
            3'd1:    ch = CH_E;
            3'd2:    ch = CH_T;
            3'd3:    ch = (sel == KW_PWM) ? CH_P : CH_T;
            3'd4:    ch = (sel == KW_PWM) ? CH_W : CH_I;
            3'd5:    ch = CH_M;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/set_command_line_parser.sv]
// Top level of the SET command line parser: input register, two keyword trackers,
// the shared number accumulator and the result register. Depends on setcmd_pkg
// and setcmd_track.
`default_nettype none

// The block reads a command line one character per transfer on the s_ channel
// (s_char_code, with s_line_end high on the final character) and, for the final
// character only, gives one verdict on the m_ channel: the command kind (none,
// SETTIM or SETPWM), the number after the keyword as a decimal mantissa, the count
// of digits after the decimal point, and a flag for mantissa or count saturation.
// Characters that are not final produce no transfer on the m_ channel.
//
// Each accepted character is captured in the input register at the accepting edge;
// from there the trackers and the accumulator consume it, and for a final
// character the verdict is loaded into the result register as it is consumed.
// m_valid is driven from the result register. One character can be accepted in
// every cycle while no final character waits for the result register; the line
// state is updated once per character by a keyword compare and a times-ten add.
//
// When the receiver stalls with a verdict waiting, characters that are not final
// keep flowing through; a final character waits in the input register until the
// result register is free, and s_ready drops behind it. After each verdict all
// line state returns to its reset value. The synchronous active-low reset
// empties both registers and clears the line state.
module set_command_line_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_line_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_command_kind,
    output logic      [31:0] m_mantissa,
    output logic      [3:0]  m_fraction_digits,
    output logic             m_saturated
);
    import setcmd_pkg::*;

    // Input register.
    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;

    // Line state.
    logic [2:0]           tim_phase_reg, tim_phase_next;
    logic [2:0]           tim_prog_reg,  tim_prog_next;
    logic [2:0]           pwm_phase_reg, pwm_phase_next;
    logic [2:0]           pwm_prog_reg,  pwm_prog_next;
    logic [MANT_BITS-1:0] acc_reg,       acc_next;
    logic [3:0]           frac_reg,      frac_next;
    logic                 point_reg,     point_next;
    logic                 ovf_reg,       ovf_next;

    // Result register.
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [31:0]          out_mant_reg;
    logic [3:0]           out_frac_reg;
    logic                 out_sat_reg;

    trk_flags_t           tim_flags;
    trk_flags_t           pwm_flags;

    logic                 advance;
    logic                 emit;
    logic [MANT_BITS+3:0] acc_x10;
    logic [1:0]           kind;

    // The held character is consumed unless it is final and the result register
    // is still occupied.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign emit    = advance && in_last_reg;
    assign s_ready = !in_valid_reg || advance;

    setcmd_track u_track_tim (
        .kw_sel        (KW_TIMER),
        .char_code     (in_char_reg),
        .phase         (tim_phase_reg),
        .progress      (tim_prog_reg),
        .point_seen    (point_reg),
        .phase_next    (tim_phase_next),
        .progress_next (tim_prog_next),
        .flags         (tim_flags)
    );

    setcmd_track u_track_pwm (
        .kw_sel        (KW_PWM),
        .char_code     (in_char_reg),
        .phase         (pwm_phase_reg),
        .progress      (pwm_prog_reg),
        .point_seen    (point_reg),
        .phase_next    (pwm_phase_next),
        .progress_next (pwm_prog_next),
        .flags         (pwm_flags)
    );

    // acc * 10 + digit, with four spare bits; any of them set means saturation.
    assign acc_x10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                   + (MANT_BITS + 4)'(in_char_reg[3:0]);

    // Only one tracker can be past its keyword at a time, so the number state is
    // shared. Finding a keyword starts a fresh number.
    always_comb begin
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        point_next = point_reg;
        ovf_next   = ovf_reg;
        priority if (tim_flags.found || pwm_flags.found) begin
            acc_next   = '0;
            frac_next  = 4'd0;
            point_next = 1'b0;
            ovf_next   = 1'b0;
        end else if (tim_flags.digit_take || pwm_flags.digit_take) begin
            if (|acc_x10[MANT_BITS+3:MANT_BITS]) begin
                acc_next = '1;
                ovf_next = 1'b1;
            end else begin
                acc_next = acc_x10[MANT_BITS-1:0];
            end
            if (point_reg) begin
                if (frac_reg == 4'hF) begin
                    ovf_next = 1'b1;
                end else begin
                    frac_next = frac_reg + 4'd1;
                end
            end
        end else if (tim_flags.point_set || pwm_flags.point_set) begin
            point_next = 1'b1;
        end else begin
            // Any other character leaves the number as it is.
            acc_next = acc_reg;
        end
    end

    // Verdict taken from the state after the final character; SETTIM first.
    always_comb begin
        if ((tim_phase_next == PH_NUM) || (tim_phase_next == PH_TRAIL)) begin
            kind = KIND_TIMER;
        end else if ((pwm_phase_next == PH_NUM) || (pwm_phase_next == PH_TRAIL)) begin
            kind = KIND_PWM;
        end else begin
            kind = KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tim_phase_reg <= PH_SEARCH;
            tim_prog_reg  <= 3'd0;
            pwm_phase_reg <= PH_SEARCH;
            pwm_prog_reg  <= 3'd0;
            acc_reg       <= '0;
            frac_reg      <= 4'd0;
            point_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (in_last_reg) begin
                    // A verdict closes the line: back to the reset state.
                    tim_phase_reg <= PH_SEARCH;
                    tim_prog_reg  <= 3'd0;
                    pwm_phase_reg <= PH_SEARCH;
                    pwm_prog_reg  <= 3'd0;
                    acc_reg       <= '0;
                    frac_reg      <= 4'd0;
                    point_reg     <= 1'b0;
                    ovf_reg       <= 1'b0;
                end else begin
                    tim_phase_reg <= tim_phase_next;
                    tim_prog_reg  <= tim_prog_next;
                    pwm_phase_reg <= pwm_phase_next;
                    pwm_prog_reg  <= pwm_prog_next;
                    acc_reg       <= acc_next;
                    frac_reg      <= frac_next;
                    point_reg     <= point_next;
                    ovf_reg       <= ovf_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_line_end;
        end
        if (emit) begin
            out_kind_reg <= kind;
            if (kind == KIND_NONE) begin
                out_mant_reg <= 32'd0;
                out_frac_reg <= 4'd0;
                out_sat_reg  <= 1'b0;
            end else begin
                out_mant_reg <= 32'(acc_next);
                out_frac_reg <= frac_next;
                out_sat_reg  <= ovf_next;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_command_kind    = out_kind_reg;
    assign m_mantissa        = out_mant_reg;
    assign m_fraction_digits = out_frac_reg;
    assign m_saturated       = out_sat_reg;

endmodule

`default_nettype wire

[hw/rtl/setcmd_track.sv]
// Keyword tracker of the SET command line parser: finds one keyword and follows
// the syntax of the number after it. Depends on setcmd_pkg.
`default_nettype none

module setcmd_track (
    input  wire logic                    kw_sel,
    input  wire logic [7:0]              char_code,
    input  wire logic [2:0]              phase,
    input  wire logic [2:0]              progress,
    input  wire logic                    point_seen,
    output logic      [2:0]              phase_next,
    output logic      [2:0]              progress_next,
    output setcmd_pkg::trk_flags_t       flags
);
    import setcmd_pkg::*;

    logic is_digit;
    logic is_point;
    logic is_space;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_point = (char_code == CH_POINT);
    assign is_space = (char_code == CH_SPACE);

    always_comb begin
        phase_next    = phase;
        progress_next = progress;
        flags         = '0;
        unique case (phase)
            PH_SEARCH: begin
                if (char_code == kw_char(kw_sel, progress)) begin
                    if (progress == KW_LAST_IDX) begin
                        phase_next    = PH_LEAD;
                        progress_next = 3'd0;
                        flags.found   = 1'b1;
                    end else begin
                        progress_next = progress + 3'd1;
                    end
                end else begin
                    // A mismatching 'S' may itself start a new keyword.
                    progress_next = (char_code == CH_S) ? 3'd1 : 3'd0;
                end
            end
            PH_LEAD, PH_NUM: begin
                if (is_digit) begin
                    phase_next       = PH_NUM;
                    flags.digit_take = 1'b1;
                end else if (is_point) begin
                    if (point_seen && (phase == PH_NUM)) begin
                        phase_next = PH_REJECT;
                    end else begin
                        phase_next      = PH_NUM;
                        flags.point_set = 1'b1;
                    end
                end else if (is_space) begin
                    if (phase == PH_NUM) begin
                        phase_next = PH_TRAIL;
                    end
                end else begin
                    phase_next = PH_REJECT;
                end
            end
            PH_TRAIL: begin
                if (!is_space) begin
                    phase_next = PH_REJECT;
                end
            end
            default: begin
                phase_next = PH_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for set_command_line_parser: directed command lines, then random
// lines, each verdict compared with a built-in line predictor.
// Depends on setcmd_pkg and set_command_line_parser.
module tb_top;
    import setcmd_pkg::*;

    // One verdict as it leaves the block on the m_ channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mantissa;
        logic [3:0]  frac;
        logic        sat;
    } verdict_t;

    typedef logic [7:0] char_q_t [$];

    // A directed command line. Where has_want is set, the verdict is typed in here and
    // the predictor's answer for that line is not used.
    typedef struct {
        string    text;
        logic     has_want;
        verdict_t want;
    } line_case_t;

    // Random characters to send after the directed lines; the directed part adds 273
    // more, giving at least 1973 transfers in total.
    localparam int RANDOM_CHARS    = 1700;
    // Cycles without any transfer before the run is declared hung. The slowest correct
    // stretch is the long receiver hold-off plus one receiver stall and one sender gap.
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_AT     = 30;
    localparam int HOLD_OFF_CYCLES = 150;
    // Cycles to run on after the last verdict before the result is printed.
    localparam int TAIL_CYCLES     = 8;

    localparam logic [63:0] MANT_MAX = ((64'd1 << (MANT_BITS - 1)) << 1) - 64'd1;
    // Keyword text, SETTIM in the low half so that the KW_TIMER index selects it.
    localparam logic [1:0][47:0] KW_WORDS = {"SETPWM", "SETTIM"};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        s_line_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_command_kind;
    logic [31:0] m_mantissa;
    logic [3:0]  m_fraction_digits;
    logic        m_saturated;

    // Predicted line state: one keyword tracker each for SETTIM and SETPWM, and the
    // number accumulator that both trackers share.
    int          kw_pos [2]    = '{0, 0};
    logic [2:0]  trk_phase [2] = '{PH_SEARCH, PH_SEARCH};
    logic [63:0] num_acc       = '0;
    logic [3:0]  frac_cnt      = '0;
    logic        point_flag    = 1'b0;
    logic        sat_flag      = 1'b0;

    verdict_t    verdict_q [$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    logic        sender_burst = 1'b0;

    set_command_line_parser u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_code       (s_char_code),
        .s_line_end        (s_line_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command_kind    (m_command_kind),
        .m_mantissa        (m_mantissa),
        .m_fraction_digits (m_fraction_digits),
        .m_saturated       (m_saturated)
    );

    always #2 aclk = ~aclk;

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Advances the predicted line state by one character. For the final character of a
    // line it returns 1 with the verdict, and the line state goes back to its reset value.
    function automatic logic parse_char(input logic [7:0] c, input logic last,
                                        output verdict_t v);
        logic [63:0] d;
        logic [2:0]  ph;
        logic        is_digit;
        int          m;
        v = '0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = 64'(c - CH_ZERO);
        for (int k = 0; k < 2; k++) begin
            ph = trk_phase[k];
            case (ph)
                PH_SEARCH: begin
                    // A mismatch restarts the search, keeping a fresh S as the
                    // first keyword character.
                    m = kw_pos[k];
                    if (c == KW_WORDS[k][47 - 8 * m -: 8]) begin
                        m++;
                        if (m == KW_LEN) begin
                            trk_phase[k] = PH_LEAD;
                            num_acc = '0;
                            frac_cnt = '0;
                            point_flag = 1'b0;
                            sat_flag = 1'b0;
                            m = 0;
                        end
                    end else begin
                        m = (c == CH_S) ? 1 : 0;
                    end
                    kw_pos[k] = m;
                end
                PH_LEAD, PH_NUM: begin
                    if (is_digit) begin
                        trk_phase[k] = PH_NUM;
                        // The mantissa sticks at its maximum once it would overflow.
                        if (num_acc > (MANT_MAX - d) / 10) begin
                            num_acc = MANT_MAX;
                            sat_flag = 1'b1;
                        end else begin
                            num_acc = num_acc * 10 + d;
                        end
                        if (point_flag) begin
                            if (frac_cnt == 4'd15) begin
                                sat_flag = 1'b1;
                            end else begin
                                frac_cnt++;
                            end
                        end
                    end else if (c == CH_POINT) begin
                        if (point_flag && ph == PH_NUM) begin
                            trk_phase[k] = PH_REJECT;
                        end else begin
                            point_flag = 1'b1;
                            trk_phase[k] = PH_NUM;
                        end
                    end else if (c == CH_SPACE) begin
                        if (ph == PH_NUM) begin
                            trk_phase[k] = PH_TRAIL;
                        end
                    end else begin
                        trk_phase[k] = PH_REJECT;
                    end
                end
                PH_TRAIL: begin
                    if (c != CH_SPACE) begin
                        trk_phase[k] = PH_REJECT;
                    end
                end
                default: trk_phase[k] = PH_REJECT;
            endcase
        end
        if (!last) begin
            return 1'b0;
        end
        // SETTIM wins when both trackers would accept the line.
        if (trk_phase[KW_TIMER] == PH_NUM || trk_phase[KW_TIMER] == PH_TRAIL) begin
            v.kind = KIND_TIMER;
        end else if (trk_phase[KW_PWM] == PH_NUM || trk_phase[KW_PWM] == PH_TRAIL) begin
            v.kind = KIND_PWM;
        end
        if (v.kind != KIND_NONE) begin
            v.mantissa = num_acc[31:0];
            v.frac = frac_cnt;
            v.sat = sat_flag;
        end
        kw_pos = '{0, 0};
        trk_phase = '{PH_SEARCH, PH_SEARCH};
        num_acc = '0;
        frac_cnt = '0;
        point_flag = 1'b0;
        sat_flag = 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_text(ref char_q_t text_q, input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    // Appends a keyword followed by a number of random shape: leading spaces, digits with
    // an optional point anywhere in the run (or none at all), and trailing spaces. About
    // one number in ten has 8 to 20 digits and may saturate the mantissa or digit count.
    function automatic void append_command(ref char_q_t text_q);
        int n_digits;
        int point_at;
        push_text(text_q, ($urandom_range(0, 1) != 0) ? "SETPWM" : "SETTIM");
        repeat ($urandom_range(0, 3)) text_q.push_back(CH_SPACE);
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        point_at = ($urandom_range(0, 1) != 0) ? $urandom_range(0, n_digits) : -1;
        for (int i = 0; i < n_digits; i++) begin
            if (i == point_at) begin
                text_q.push_back(CH_POINT);
            end
            text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (point_at == n_digits) begin
            text_q.push_back(CH_POINT);
        end
        repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
    endfunction

    // Most lines are well formed with random content; the rest are pure noise over the
    // whole character range, lines with one character spoiled, and lines with two commands.
    function automatic void compose_random_line(ref char_q_t text_q);
        int shape;
        int idx;
        text_q = {};
        shape = $urandom_range(0, 9);
        if (shape < 2) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        // Leading junk, biased toward partial keyword matches.
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(8'($urandom_range(0, 255)));
                1:       text_q.push_back(CH_S);
                2:       text_q.push_back(CH_E);
                default: text_q.push_back(CH_T);
            endcase
        end
        append_command(text_q);
        if (shape == 2) begin
            idx = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0:       text_q[idx] = CH_SPACE;
                1:       text_q[idx] = CH_POINT;
                2:       text_q[idx] = CH_ZERO + 8'($urandom_range(0, 9));
                default: text_q[idx] = 8'($urandom_range(0, 255));
            endcase
        end else if (shape == 3) begin
            if ($urandom_range(0, 1) != 0) begin
                text_q.push_back(CH_SPACE);
            end
            append_command(text_q);
        end
    endfunction

    // Offers one character and waits for its transfer. Valid is only lowered when a gap
    // follows, so a back-to-back character never sees valid drop and rise in one step.
    task automatic send_char(input logic [7:0] c, input logic last, input logic has_want,
                             input verdict_t want);
        int       gap;
        verdict_t v;
        gap = sender_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        s_line_end <= last;
        do @(posedge aclk); while (!s_ready);
        if (parse_char(c, last, v)) begin
            verdict_q.push_back(has_want ? want : v);
        end
    endtask

    task automatic send_line(input char_q_t text_q, input logic has_want, input verdict_t want);
        // Switching between gapped and back-to-back lines now and then gives long
        // stretches with no idling at all.
        if ($urandom_range(0, 3) == 0) begin
            sender_burst = !sender_burst;
        end
        foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1, has_want, want);
        end
    endtask

    // Directed lines. Verdicts are typed in for the plain cases, the rejections and the
    // saturation limits; the rest go through the predictor.
    line_case_t directed_lines [22] = '{
        '{"SETTIM 5",  1'b1, '{KIND_TIMER, 32'd5, 4'd0, 1'b0}},
        // A lone point is a number of value zero.
        '{"SETPWM.",   1'b1, '{KIND_PWM, 32'd0, 4'd0, 1'b0}},
        '{"5",         1'b1, '0},
        // Keyword with nothing after it, and keyword with spaces only.
        '{"SETTIM",    1'b1, '0},
        '{"SETPWM   ", 1'b1, '0},
        // Largest mantissa that fits, then one past it.
        '{"SETTIM4294967295", 1'b1, '{KIND_TIMER, 32'hFFFF_FFFF, 4'd0, 1'b0}},
        '{"SETTIM4294967296", 1'b1, '{KIND_TIMER, 32'hFFFF_FFFF, 4'd0, 1'b1}},
        // Sixteen fraction digits saturate the count; fifteen just fit.
        '{"SETPWM.0000000000000000", 1'b1, '{KIND_PWM, 32'd0, 4'd15, 1'b1}},
        '{"SETPWM 0.000000000000001", 1'b1, '{KIND_PWM, 32'd1, 4'd15, 1'b0}},
        '{"xySETTIM  12.5  ", 1'b0, '0},
        // Second decimal point.
        '{"SETTIM1.2.3", 1'b1, '0},
        '{"SETTIM.5.",   1'b1, '0},
        // Stray character after the number, and a digit after trailing spaces.
        '{"SETTIM 7x",   1'b1, '0},
        '{"SETTIM 7 8",  1'b1, '0},
        // A broken keyword followed by a good one.
        '{"SESETTIM9",   1'b0, '0},
        // Both keywords on one line, in either order.
        '{"SETTIM5 SETPWM3", 1'b0, '0},
        '{"SETPWM1SETTIM2",  1'b0, '0},
        '{"SETTIMSETPWM4",   1'b0, '0},
        // A repeated keyword cannot rescue a line rejected after the first one.
        '{"SETTIM1 x SETTIM2", 1'b1, '0},
        '{"SETPWM  3 ", 1'b1, '{KIND_PWM, 32'd3, 4'd0, 1'b0}},
        '{"SETTIM 1.",  1'b1, '{KIND_TIMER, 32'd1, 4'd0, 1'b0}},
        '{"SETPWM 99999999999.99", 1'b0, '0}
    };

    // Sender: directed lines, then random lines, then the drain and the verdict.
    initial begin : sender
        char_q_t text_q;
        int      random_chars;
        random_chars = 0;
        wait (aresetn);
        @(posedge aclk);
        foreach (directed_lines[r]) begin
            text_q = {};
            push_text(text_q, directed_lines[r].text);
            send_line(text_q, directed_lines[r].has_want, directed_lines[r].want);
        end
        while (random_chars < RANDOM_CHARS) begin
            compose_random_line(text_q);
            send_line(text_q, 1'b0, '0);
            random_chars += text_q.size();
        end
        s_valid <= 1'b0;
        // The watchdog covers a verdict that never arrives.
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: a random stall before each verdict, with back-to-back stretches, and one
    // long hold-off so that a final character backs up and s_ready drops while the
    // sender keeps offering.
    initial begin : receiver
        int   stall;
        int   taken;
        logic burst;
        taken = 0;
        burst = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                burst = !burst;
            end
            stall = burst ? 0 : $urandom_range(0, 11);
            if (taken == HOLD_OFF_AT) begin
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Each verdict transfer is checked field by field against the oldest expectation.
    always @(posedge aclk) begin : check_verdict
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected: kind %0d, mantissa %0d",
                       m_command_kind, m_mantissa);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                if (m_command_kind !== want.kind) begin
                    $error("command_kind: expected %0d, got %0d", want.kind, m_command_kind);
                    mismatches++;
                end
                if (m_mantissa !== want.mantissa) begin
                    $error("mantissa: expected %0d, got %0d", want.mantissa, m_mantissa);
                    mismatches++;
                end
                if (m_fraction_digits !== want.frac) begin
                    $error("fraction_digits: expected %0d, got %0d", want.frac,
                           m_fraction_digits);
                    mismatches++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transfer happens on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
